FILE: rtl/coi_pkg.sv
// Shared types and register codes for the cooler output interlock.
// No dependencies; every other file imports this package.
package coi_pkg;

   typedef enum logic [1:0] {
      KIND_TICK     = 2'd0,
      KIND_COMMAND  = 2'd1,
      KIND_EVALUATE = 2'd2,
      KIND_SAFE_STOP = 2'd3
   } kind_type;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PUMP_MODE    = 3'd0,
      CSR_SWING_MODE   = 3'd1,
      CSR_DRAIN_ENABLE = 3'd2,
      CSR_SENSOR_MODE  = 3'd3,
      CSR_SENSOR_DELAY = 3'd4
   } csr_addr_type;

   // Mode codes shared by pump, swing and sensor registers
   localparam logic [1:0] MODE_OFF = 2'd0;
   localparam logic [1:0] MODE_NO  = 2'd1;
   localparam logic [1:0] MODE_NC  = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic        water_sense;
      logic [1:0]  buttons;
      logic        system_on;
      logic        pump_request;
      logic        swing_request;
      logic        exhaust_request;
      logic [1:0]  drain_status;
      logic        reverse_direction;
      logic [15:0] freq_request;
      logic        trip;
      logic        motor_turning;
   } req_type;

   typedef struct packed {
      logic        pump_pin;
      logic        louvre_pin;
      logic        drain_pin;
      logic        fan_enable;
      logic        fan_reverse;
      logic        motor_off;
      logic        motor_run_cmd;
      logic        water_confirmed;
      logic [15:0] freq_target;
   } rsp_type;

   typedef struct packed {
      logic [1:0] pump_mode;
      logic [1:0] swing_mode;
      logic       drain_enable;
      logic [1:0] sensor_mode;
      logic [7:0] sensor_delay;
   } cfg_type;

endpackage

FILE: rtl/coi_if.sv
// Valid/ready channel interfaces for items, results and register writes.
// Depends on coi_pkg.
interface coi_req_if import coi_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface coi_rsp_if import coi_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface coi_csr_if import coi_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/coi_csr.sv
// Configuration register file: mode, enable and sensor delay registers.
// Depends on coi_pkg.
module coi_csr import coi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_ADDR_W-1:0] wr_addr,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_addr)
            CSR_PUMP_MODE:    cfg_in.pump_mode    = wr_data[1:0];
            CSR_SWING_MODE:   cfg_in.swing_mode   = wr_data[1:0];
            CSR_DRAIN_ENABLE: cfg_in.drain_enable = wr_data[0];
            CSR_SENSOR_MODE:  cfg_in.sensor_mode  = wr_data[1:0];
            CSR_SENSOR_DELAY: cfg_in.sensor_delay = wr_data[7:0];
            default:          cfg_in = cfg_ff; // unmapped: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pump_mode: MODE_NO, swing_mode: MODE_NO, drain_enable: 1'b1,
                     sensor_mode: MODE_NO, sensor_delay: 8'd5};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/coi_core.sv
// Interlock state and the single-pass next-state logic for one item.
// Depends on coi_pkg.
module coi_core import coi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   logic        start_latch_ff, start_latch_in;
   logic        remote_on_ff, remote_on_in;
   logic        remote_pump_ff, remote_pump_in;
   logic        remote_swing_ff, remote_swing_in;
   logic        remote_exhaust_ff, remote_exhaust_in;
   logic [1:0]  remote_drain_ff, remote_drain_in;
   logic        direction_ff, direction_in;
   logic [15:0] held_freq_ff, held_freq_in;
   logic        last_reading_ff, last_reading_in;
   logic [7:0]  holdoff_ff, holdoff_in;
   logic        stable_ff, stable_in;
   logic        pin_pump_ff, pin_pump_in;
   logic        pin_swing_ff, pin_swing_in;
   logic        pin_drain_ff, pin_drain_in;
   logic        pin_motor_ff, pin_motor_in;
   logic        flag_run_ff, flag_run_in;
   logic        flag_off_ff, flag_off_in;
   logic        flag_rev_ff, flag_rev_in;

   logic reading;
   logic drain_act;
   logic permit;
   logic motor_act;
   logic pump_ok;
   logic swing_ok;
   logic pump_idle_level;
   logic swing_idle_level;
   logic latch_cmd;

   function automatic logic pump_level(input logic [1:0] mode, input logic on);
      return (mode == MODE_NC) ? !on : on;
   endfunction

   function automatic logic swing_level(input logic [1:0] mode, input logic on);
      logic lvl;
      if (mode == MODE_OFF) begin
         lvl = 1'b0;
      end else begin
         lvl = (mode == MODE_NC) ? !on : on;
      end
      return lvl;
   endfunction

   always_comb begin
      // Sensor polarity; the unused mode code reads as active low
      if (cfg.sensor_mode == MODE_OFF) begin
         reading = 1'b0;
      end else if (cfg.sensor_mode == MODE_NO) begin
         reading = item.water_sense;
      end else begin
         reading = !item.water_sense;
      end

      drain_act = (remote_drain_ff != 2'd0) && cfg.drain_enable && !item.trip;
      permit    = remote_on_ff && start_latch_ff && !drain_act && !item.trip;
      motor_act = (remote_on_ff && start_latch_ff &&
                   !((remote_drain_ff != 2'd0) && cfg.drain_enable)) || item.motor_turning;
      pump_ok   = remote_on_ff && remote_pump_ff && !remote_exhaust_ff &&
                  !((remote_drain_ff != 2'd0) && cfg.drain_enable) &&
                  (cfg.pump_mode != MODE_OFF) && stable_ff && !item.trip;
      swing_ok  = motor_act && remote_swing_ff &&
                  !((remote_drain_ff != 2'd0) && cfg.drain_enable) &&
                  (cfg.swing_mode != MODE_OFF) && !remote_exhaust_ff && !item.trip;
      pump_idle_level  = pump_level(cfg.pump_mode, 1'b0);
      swing_idle_level = swing_level(cfg.swing_mode, 1'b0);

      // Start then stop, and drop the latch when the system is off
      latch_cmd = start_latch_ff;
      if (item.buttons[0]) begin
         latch_cmd = 1'b1;
      end
      if (item.buttons[1] || !item.system_on) begin
         latch_cmd = 1'b0;
      end
   end

   always_comb begin
      start_latch_in    = start_latch_ff;
      remote_on_in      = remote_on_ff;
      remote_pump_in    = remote_pump_ff;
      remote_swing_in   = remote_swing_ff;
      remote_exhaust_in = remote_exhaust_ff;
      remote_drain_in   = remote_drain_ff;
      direction_in      = direction_ff;
      held_freq_in      = held_freq_ff;
      last_reading_in   = last_reading_ff;
      holdoff_in        = holdoff_ff;
      stable_in         = stable_ff;
      pin_pump_in       = pin_pump_ff;
      pin_swing_in      = pin_swing_ff;
      pin_drain_in      = pin_drain_ff;
      pin_motor_in      = pin_motor_ff;
      flag_run_in       = flag_run_ff;
      flag_off_in       = flag_off_ff;
      flag_rev_in       = flag_rev_ff;

      unique case (item.kind)
         KIND_TICK: begin
            if (reading != last_reading_ff) begin
               last_reading_in = reading;
               holdoff_in      = cfg.sensor_delay;
            end else if (holdoff_ff != 8'd0) begin
               holdoff_in = holdoff_ff - 8'd1;
            end else begin
               stable_in = reading;
            end
         end
         KIND_COMMAND: begin
            start_latch_in    = latch_cmd;
            remote_on_in      = item.system_on;
            remote_pump_in    = item.pump_request;
            remote_swing_in   = item.swing_request;
            remote_exhaust_in = item.exhaust_request;
            remote_drain_in   = item.drain_status;
            direction_in      = item.reverse_direction;
            held_freq_in      = item.freq_request;
         end
         KIND_EVALUATE: begin
            if (drain_act) begin
               pin_drain_in = 1'b1;
               pin_pump_in  = pump_idle_level;
               pin_swing_in = swing_idle_level;
               flag_run_in  = 1'b0;
            end else begin
               pin_drain_in = 1'b0;
               pin_pump_in  = pump_level(cfg.pump_mode, pump_ok);
               pin_swing_in = swing_level(cfg.swing_mode, swing_ok);
               flag_run_in  = permit;
            end
            flag_rev_in  = direction_ff ^ remote_exhaust_ff;
            pin_motor_in = (!drain_act && permit) || item.motor_turning;
            flag_off_in  = !((!drain_act && permit) || item.motor_turning);
         end
         KIND_SAFE_STOP: begin
            start_latch_in = 1'b0;
            flag_run_in    = 1'b0;
            pin_pump_in    = pump_idle_level;
            pin_swing_in   = swing_idle_level;
            pin_drain_in   = 1'b0;
            // Leave the motor pin alone while it still turns
            if (!item.motor_turning) begin
               pin_motor_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_latch_ff    <= 1'b0;
         remote_on_ff      <= 1'b0;
         remote_pump_ff    <= 1'b0;
         remote_swing_ff   <= 1'b0;
         remote_exhaust_ff <= 1'b0;
         remote_drain_ff   <= 2'd0;
         direction_ff      <= 1'b0;
         held_freq_ff      <= 16'd0;
         last_reading_ff   <= 1'b0;
         holdoff_ff        <= 8'd0;
         stable_ff         <= 1'b0;
         pin_pump_ff       <= 1'b0;
         pin_swing_ff      <= 1'b0;
         pin_drain_ff      <= 1'b0;
         pin_motor_ff      <= 1'b0;
         flag_run_ff       <= 1'b0;
         flag_off_ff       <= 1'b1;
         flag_rev_ff       <= 1'b0;
      end else if (advance) begin
         start_latch_ff    <= start_latch_in;
         remote_on_ff      <= remote_on_in;
         remote_pump_ff    <= remote_pump_in;
         remote_swing_ff   <= remote_swing_in;
         remote_exhaust_ff <= remote_exhaust_in;
         remote_drain_ff   <= remote_drain_in;
         direction_ff      <= direction_in;
         held_freq_ff      <= held_freq_in;
         last_reading_ff   <= last_reading_in;
         holdoff_ff        <= holdoff_in;
         stable_ff         <= stable_in;
         pin_pump_ff       <= pin_pump_in;
         pin_swing_ff      <= pin_swing_in;
         pin_drain_ff      <= pin_drain_in;
         pin_motor_ff      <= pin_motor_in;
         flag_run_ff       <= flag_run_in;
         flag_off_ff       <= flag_off_in;
         flag_rev_ff       <= flag_rev_in;
      end
   end

   assign result = '{pump_pin: pin_pump_in, louvre_pin: pin_swing_in,
                     drain_pin: pin_drain_in, fan_enable: pin_motor_in,
                     fan_reverse: flag_rev_in, motor_off: flag_off_in,
                     motor_run_cmd: flag_run_in, water_confirmed: stable_in,
                     freq_target: held_freq_in};

endmodule

FILE: rtl/cooler_output_interlock.sv
// Cooler output interlock: input register, single-pass interlock logic, result register.
// An accepted item waits in the input register until the result register is free or its
// result is taken; its result is then registered into the result register.
// Throughput: one item per cycle while results are taken; back-pressure stalls the items.
// Reset: synchronous, active high; registers return to their defaults, pins low,
// motor flagged off, and both item registers empty.
module cooler_output_interlock import coi_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   coi_req_if.sink   req_chan,
   coi_rsp_if.source rsp_chan,
   coi_csr_if.sink   csr_chan
);

   cfg_type cfg;
   logic    in_vld_ff, in_vld_in;
   req_type in_item_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_item_ff;
   rsp_type result;
   logic    advance;
   logic    req_fire;

   assign csr_chan.ready = 1'b1;

   coi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_chan.valid),
      .wr_addr (csr_chan.addr),
      .wr_data (csr_chan.data),
      .cfg     (cfg)
   );

   // Move the held item into the result register when that register is free or being read
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   coi_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   always_comb begin
      in_vld_in  = req_fire || (in_vld_ff && !advance);
      out_vld_in = advance || (out_vld_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_chan.payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.payload = out_item_ff;

endmodule
